// ----- sv/xcfp_pkg.sv -----
// Shared types, character codes and the command string table of the
// checksum frame parser. No dependencies.

package xcfp_pkg;

  localparam int FRAME_BYTES_DEF = 128;
  localparam int NUM_CMDS        = 21;
  localparam int CMD_SLOTS       = 16;
  localparam int SLOT_W          = 4;
  localparam int CODE_W          = 5;

  localparam logic [CODE_W-1:0] CMD_UNKNOWN = 5'd21;

  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEP   = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_START = 8'h3C;
  localparam logic [7:0] CH_END   = 8'h3E;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SEP   = 2'd1,
    ST_MISMATCH = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] value;
    logic       negative;
  } chk_t;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [7:0]        key;
    status_t           status;
    logic [CODE_W-1:0] code;
    logic [7:0]        cxor;
    logic [7:0]        rxsum;
  } res_t;

  // Each command is left-justified in a 16-byte slot and padded with zeros.
  function automatic logic [CMD_SLOTS*8-1:0] cmd_text(input logic [CODE_W-1:0] k);
    logic [CMD_SLOTS*8-1:0] s;
    unique case (k)
      5'd0:    s = {"MODE1:START",   {5{8'h00}}};
      5'd1:    s = {"MODE2:START",   {5{8'h00}}};
      5'd2:    s = {"MODE3:START",   {5{8'h00}}};
      5'd3:    s = {"MODE4:START",   {5{8'h00}}};
      5'd4:    s = {"MODE5:START",   {5{8'h00}}};
      5'd5:    s = {"MODE:STOP",     {7{8'h00}}};
      5'd6:    s = {"ROD:ROTATE",    {6{8'h00}}};
      5'd7:    s = {"ROD:RETURN",    {6{8'h00}}};
      5'd8:    s = {"ROD:DROP",      {8{8'h00}}};
      5'd9:    s = {"MOVE:MERGE",    {6{8'h00}}};
      5'd10:   s = {"MOVE:STOP",     {7{8'h00}}};
      5'd11:   s = {"MOVE:SEPARATE", {3{8'h00}}};
      5'd12:   s = {"CLAMP:OPEN",    {6{8'h00}}};
      5'd13:   s = {"CLAMP:CLOSE",   {5{8'h00}}};
      5'd14:   s = {"PLATFORM:UP",   {5{8'h00}}};
      5'd15:   s = {"PLATFORM:DOWN", {3{8'h00}}};
      5'd16:   s = {"PLATFORM:STOP", {3{8'h00}}};
      5'd17:   s = {"SUCTION:ON",    {6{8'h00}}};
      5'd18:   s = {"SUCTION:OFF",   {5{8'h00}}};
      5'd19:   s = {"BLOWER:ON",     {7{8'h00}}};
      5'd20:   s = {"BLOWER:OFF",    {6{8'h00}}};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] cmd_char(input logic [CODE_W-1:0] k,
                                          input logic [SLOT_W-1:0] slot);
    logic [CMD_SLOTS*8-1:0] s;
    s = cmd_text(k);
    return s[(CMD_SLOTS-1-int'(slot))*8 +: 8];
  endfunction

endpackage

// ----- sv/xcfp_cmd_match.sv -----
// Narrows the set of candidate commands by the character at one position.
// Depends on xcfp_pkg for the command table.

module xcfp_cmd_match #(
  parameter int CNT_W = 7
) (
  input  logic [xcfp_pkg::NUM_CMDS-1:0] mask,
  input  logic [CNT_W-1:0]              pos,
  input  logic [7:0]                    chr,
  output logic [xcfp_pkg::NUM_CMDS-1:0] mask_nxt
);

  localparam int PW = (CNT_W > xcfp_pkg::SLOT_W) ? CNT_W : xcfp_pkg::SLOT_W;

  logic [PW-1:0]               pos_ext;
  logic                        in_range;
  logic [xcfp_pkg::SLOT_W-1:0] slot;

  assign pos_ext  = PW'(pos);
  assign in_range = pos_ext < PW'(xcfp_pkg::CMD_SLOTS);
  assign slot     = pos_ext[xcfp_pkg::SLOT_W-1:0];

  always_comb begin
    for (int k = 0; k < xcfp_pkg::NUM_CMDS; k++) begin
      if (in_range) begin
        mask_nxt[k] = mask[k] &&
                      (xcfp_pkg::cmd_char(xcfp_pkg::CODE_W'(k), slot) == chr);
      end else begin
        mask_nxt[k] = mask[k] && (chr == xcfp_pkg::CH_NUL);
      end
    end
  end

endmodule

// ----- sv/xcfp_hex_parse.sv -----
// One step of the base-16 checksum text parser (whitespace, sign, digits).
// Depends on xcfp_pkg for the parser state type and character codes.

module xcfp_hex_parse (
  input  xcfp_pkg::chk_t chk,
  input  logic [7:0]     chr,
  output xcfp_pkg::chk_t chk_nxt
);

  logic       is_digit;
  logic [3:0] digit;
  logic       is_space;
  logic       is_sign;

  always_comb begin
    is_digit = 1'b1;
    digit    = 4'd0;
    if (chr >= 8'h30 && chr <= 8'h39) begin
      digit = 4'(chr - 8'h30);
    end else if (chr >= 8'h61 && chr <= 8'h66) begin
      digit = 4'(chr - 8'h57);
    end else if (chr >= 8'h41 && chr <= 8'h46) begin
      digit = 4'(chr - 8'h37);
    end else begin
      is_digit = 1'b0;
    end
  end

  assign is_space = (chr == xcfp_pkg::CH_SPACE) || (chr == xcfp_pkg::CH_TAB) ||
                    (chr == xcfp_pkg::CH_LF) || (chr == xcfp_pkg::CH_VT) ||
                    (chr == xcfp_pkg::CH_FF) || (chr == xcfp_pkg::CH_CR);
  assign is_sign  = (chr == xcfp_pkg::CH_PLUS) || (chr == xcfp_pkg::CH_MINUS);

  always_comb begin
    chk_nxt = chk;
    unique case (chk.phase)
      xcfp_pkg::PH_START: begin
        if (is_space) begin
          chk_nxt.phase = xcfp_pkg::PH_START;
        end else if (is_sign) begin
          chk_nxt.negative = (chr == xcfp_pkg::CH_MINUS);
          chk_nxt.phase    = xcfp_pkg::PH_SIGN;
        end else if (is_digit) begin
          chk_nxt.value = {chk.value[3:0], digit};
          chk_nxt.phase = xcfp_pkg::PH_DIGITS;
        end else begin
          chk_nxt.phase = xcfp_pkg::PH_STOP;
        end
      end
      xcfp_pkg::PH_SIGN, xcfp_pkg::PH_DIGITS: begin
        if (is_digit) begin
          chk_nxt.value = {chk.value[3:0], digit};
          chk_nxt.phase = xcfp_pkg::PH_DIGITS;
        end else begin
          chk_nxt.phase = xcfp_pkg::PH_STOP;
        end
      end
      xcfp_pkg::PH_STOP: begin
        chk_nxt.phase = xcfp_pkg::PH_STOP;
      end
      default: begin
        chk_nxt.phase = xcfp_pkg::PH_STOP;
      end
    endcase
  end

endmodule

// ----- sv/xcfp_frame_core.sv -----
// Frame state registers and the per-byte update that forms each result.
// Depends on xcfp_pkg, xcfp_cmd_match and xcfp_hex_parse.

module xcfp_frame_core #(
  parameter int FRAME_BYTES = xcfp_pkg::FRAME_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [7:0]     chr,
  output xcfp_pkg::res_t res
);

  localparam int CNT_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(FRAME_BYTES - 1);

  logic                        in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        sep_r, sep_nxt;
  logic                        trunc_r, trunc_nxt;
  logic [7:0]                  xor_r, xor_nxt;
  logic [1:0]                  chars_r, chars_nxt;
  xcfp_pkg::chk_t              chk_r, chk_nxt;
  logic [xcfp_pkg::NUM_CMDS-1:0] mask_r, mask_nxt;

  logic                          is_close;
  logic [7:0]                    match_chr;
  logic [xcfp_pkg::NUM_CMDS-1:0] mask_m;
  logic [xcfp_pkg::NUM_CMDS-1:0] final_mask;
  xcfp_pkg::chk_t                chk_m;
  logic [xcfp_pkg::CODE_W-1:0]   code;
  logic [7:0]                    rxsum;

  assign is_close  = (chr == xcfp_pkg::CH_END) || (chr == xcfp_pkg::CH_CR) ||
                     (chr == xcfp_pkg::CH_LF);
  assign match_chr = (is_close || chr == xcfp_pkg::CH_SEP) ? xcfp_pkg::CH_NUL : chr;

  xcfp_cmd_match #(
    .CNT_W(CNT_W)
  ) u_match (
    .mask    (mask_r),
    .pos     (count_r),
    .chr     (match_chr),
    .mask_nxt(mask_m)
  );

  xcfp_hex_parse u_hex (
    .chk    (chk_r),
    .chr    (chr),
    .chk_nxt(chk_m)
  );

  assign final_mask = (!sep_r && !trunc_r) ? mask_m : mask_r;

  always_comb begin
    code = xcfp_pkg::CMD_UNKNOWN;
    for (int k = xcfp_pkg::NUM_CMDS - 1; k >= 0; k--) begin
      if (final_mask[k]) begin
        code = xcfp_pkg::CODE_W'(k);
      end
    end
  end

  always_comb begin
    if (!sep_r) begin
      rxsum = 8'd0;
    end else if (chk_r.negative) begin
      rxsum = 8'd0 - chk_r.value;
    end else begin
      rxsum = chk_r.value;
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    sep_nxt      = sep_r;
    trunc_nxt    = trunc_r;
    xor_nxt      = xor_r;
    chars_nxt    = chars_r;
    chk_nxt      = chk_r;
    mask_nxt     = mask_r;
    res          = '0;
    if (en) begin
      if (chr == xcfp_pkg::CH_START) begin
        in_frame_nxt   = 1'b1;
        count_nxt      = '0;
        sep_nxt        = 1'b0;
        trunc_nxt      = 1'b0;
        xor_nxt        = 8'd0;
        chars_nxt      = 2'd0;
        chk_nxt.phase    = xcfp_pkg::PH_START;
        chk_nxt.value    = 8'd0;
        chk_nxt.negative = 1'b0;
        mask_nxt       = '1;
      end else if (!in_frame_r) begin
        res.valid = 1'b1;
        res.kind  = xcfp_pkg::KIND_KEY;
        res.key   = chr;
      end else if (is_close) begin
        in_frame_nxt = 1'b0;
        if (count_r != '0) begin
          mask_nxt  = final_mask;
          res.valid = 1'b1;
          res.kind  = xcfp_pkg::KIND_FRAME;
          res.code  = code;
          res.cxor  = xor_r;
          res.rxsum = rxsum;
          if (!sep_r) begin
            res.status = xcfp_pkg::ST_NO_SEP;
          end else if (xor_r == rxsum) begin
            res.status = xcfp_pkg::ST_OK;
          end else begin
            res.status = xcfp_pkg::ST_MISMATCH;
          end
        end
      end else if (count_r < CNT_LIM) begin
        count_nxt = count_r + 1'b1;
        if (!trunc_r) begin
          priority if (chr == xcfp_pkg::CH_NUL) begin
            if (!sep_r) begin
              mask_nxt = mask_m;
            end
            trunc_nxt = 1'b1;
          end else if (!sep_r) begin
            mask_nxt = mask_m;
            if (chr == xcfp_pkg::CH_SEP) begin
              sep_nxt = 1'b1;
            end else begin
              xor_nxt = xor_r ^ chr;
            end
          end else begin
            if (chars_r < 2'd2) begin
              chars_nxt = chars_r + 1'b1;
              chk_nxt   = chk_m;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r     <= 1'b0;
      count_r        <= '0;
      sep_r          <= 1'b0;
      trunc_r        <= 1'b0;
      xor_r          <= 8'd0;
      chars_r        <= 2'd0;
      chk_r.phase    <= xcfp_pkg::PH_START;
      chk_r.value    <= 8'd0;
      chk_r.negative <= 1'b0;
      mask_r         <= '1;
    end else begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      sep_r      <= sep_nxt;
      trunc_r    <= trunc_nxt;
      xor_r      <= xor_nxt;
      chars_r    <= chars_nxt;
      chk_r      <= chk_nxt;
      mask_r     <= mask_nxt;
    end
  end

endmodule

// ----- sv/xor_checked_command_frame_parser_unit.sv -----
// Command frame parser with XOR checksum check: input register, frame core
// and result register. Depends on xcfp_pkg and xcfp_frame_core.
//
// Usage: one received byte is offered per request on the in_ channel. A '<'
// byte opens a frame, and '>', CR or LF closes it. Each closed frame with
// payload gives one report request on the out_ channel: status, command
// code, computed and received checksum. A byte seen outside a frame is
// passed on as a key request; bytes inside a frame give no request.
// A result passes from the input register through the frame core into
// the result register and is then offered on out_.
// Throughput: one byte per cycle while out_ is not stalled; the frame
// update is combinational between the input and result registers.
// When out_stall is high a valid result in the result register holds, the input register
// fills, and in_stall rises only once both are occupied; when the result is
// taken the next byte moves up in the same cycle.
// Reset (rst_n low, synchronous) empties both registers and leaves the
// parser outside a frame with its frame state cleared.

module xor_checked_command_frame_parser_unit #(
  parameter int FRAME_BYTES = xcfp_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_key_byte,
  output logic [1:0]  out_frame_status,
  output logic [4:0]  out_command_code,
  output logic [7:0]  out_computed_checksum,
  output logic [7:0]  out_received_checksum
);

  logic           s1_valid_r, s1_valid_nxt;
  logic [7:0]     s1_byte_r;
  logic           adv;
  logic           in_take;
  xcfp_pkg::res_t res;
  xcfp_pkg::res_t out_r;
  logic           out_valid_r;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  xcfp_frame_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (adv),
    .chr  (s1_byte_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (adv) begin
        out_valid_r <= res.valid;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_kind       = out_r.kind;
  assign out_key_byte          = out_r.key;
  assign out_frame_status      = out_r.status;
  assign out_command_code      = out_r.code;
  assign out_computed_checksum = out_r.cxor;
  assign out_received_checksum = out_r.rxsum;

endmodule
